FILE: rtl/lcd_pkg.sv
// Package for the line command decoder: codes, state type, command table.
// No dependencies; the interface, top level and parser files refer to it by scoped name.

package lcd_pkg;

	localparam int LINE_LENGTH = 32;
	localparam int NUM_CMDS    = 9;
	localparam int BYTE_W      = 8;
	localparam int CMD_W       = 4;
	localparam int ARG_W       = 8;

	// Special characters
	localparam logic [BYTE_W-1:0] CH_NUL   = 8'd0;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
	localparam logic [BYTE_W-1:0] CH_ZERO  = "0";
	localparam logic [BYTE_W-1:0] CH_NINE  = "9";
	localparam logic [BYTE_W-1:0] CH_P     = "P";
	localparam logic [ARG_W-1:0]  ARG_MAX  = 8'd255;

	typedef enum logic [CMD_W-1:0] {
		CMD_FWD       = 4'd0,
		CMD_REV       = 4'd1,
		CMD_LEFT      = 4'd2,
		CMD_RIGHT     = 4'd3,
		CMD_STOP      = 4'd4,
		CMD_REPORT    = 4'd5,
		CMD_ENC_RST   = 4'd6,
		CMD_PUMP_ON   = 4'd7,
		CMD_PUMP_HALT = 4'd8
	} cmd_code_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MATCH,
		ST_FINISH
	} lcd_state_t;

	// One character step from the sequencer to the parser
	typedef struct packed {
		logic              clear;
		logic              step;
		logic [BYTE_W-1:0] ch;
	} lcd_step_t;

	// Decode outcome from the parser
	typedef struct packed {
		logic             hit;
		cmd_code_t        command;
		logic [ARG_W-1:0] argument;
	} lcd_result_t;

	// Command text, left justified in eight characters
	function automatic logic [63:0] cmd_text(input cmd_code_t k);
		logic [63:0] t;
		begin
			case (k)
				CMD_FWD:       t = {"F:", 48'h0};
				CMD_REV:       t = {"R:", 48'h0};
				CMD_LEFT:      t = {"L:", 48'h0};
				CMD_RIGHT:     t = {"T:", 48'h0};
				CMD_STOP:      t = {"S", 56'h0};
				CMD_REPORT:    t = {"E", 56'h0};
				CMD_ENC_RST:   t = {"RESET", 24'h0};
				CMD_PUMP_ON:   t = "PUMP_ON:";
				CMD_PUMP_HALT: t = "PUMP_OFF";
				default:       t = 64'h0;
			endcase
			return t;
		end
	endfunction

	function automatic logic [BYTE_W-1:0] cmd_char(input cmd_code_t k, input logic [2:0] i);
		logic [63:0] sh;
		begin
			sh = cmd_text(k) << {i, 3'b000};
			return sh[63:56];
		end
	endfunction

	function automatic logic [3:0] cmd_len(input cmd_code_t k);
		logic [3:0] n;
		begin
			case (k)
				CMD_FWD, CMD_REV, CMD_LEFT, CMD_RIGHT: n = 4'd2;
				CMD_STOP, CMD_REPORT:                  n = 4'd1;
				CMD_ENC_RST:                           n = 4'd5;
				CMD_PUMP_ON, CMD_PUMP_HALT:            n = 4'd8;
				default:                               n = 4'd0;
			endcase
			return n;
		end
	endfunction

	// Prefix commands carry a decimal argument
	function automatic logic cmd_prefix(input cmd_code_t k);
		logic p;
		begin
			case (k)
				CMD_FWD, CMD_REV, CMD_LEFT, CMD_RIGHT, CMD_PUMP_ON: p = 1'b1;
				default:                                            p = 1'b0;
			endcase
			return p;
		end
	endfunction

endpackage

FILE: rtl/lcd_if.sv
// Valid/ready channel interfaces: received bytes in, decoded commands out.
// Depends on lcd_pkg for field widths.

interface lcd_rx_if;
	logic                         valid;
	logic                         ready;
	logic [lcd_pkg::BYTE_W-1:0]   rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lcd_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [lcd_pkg::CMD_W-1:0]    command;
	logic [lcd_pkg::ARG_W-1:0]    argument;

	modport source (output valid, output command, output argument, input ready);
	modport sink   (input valid, input command, input argument, output ready);
endinterface

FILE: rtl/line_command_decoder_top.sv
// Top level of the line command decoder: line store, sequencer, result register.
// Depends on lcd_pkg, lcd_if, lcd_ram and lcd_parser.

// A byte other than newline is written to the line store when taken (a full store
// drops the byte and restarts the line). A newline after at least one stored byte
// starts decoding and the input stays not ready until it is done: the single read
// port of the line store is swept twice, once to find the line end (first zero
// byte, one trailing CR removed) and once to match commands and accumulate the
// argument. A matched command is held in an output register; while an earlier
// command there is still unread, decoding holds in its last step with the input
// not ready.

module line_command_decoder_top #(
	parameter int LINE_LENGTH = lcd_pkg::LINE_LENGTH
) (
	input  logic             clk,
	input  logic             arst_n,
	lcd_rx_if.sink           rx,
	lcd_cmd_if.source        cmd
);

	localparam int            IW   = $clog2(LINE_LENGTH);
	localparam logic [IW-1:0] LAST = IW'(LINE_LENGTH - 1);

	lcd_pkg::lcd_state_t  state_q, state_nx;
	logic [IW-1:0]        fill_q, len_q, rd_q, di_s1;
	logic                 dv_s1;
	logic [7:0]           last_q;
	logic [7:0]           rdata;
	logic                 out_valid_q;
	logic [3:0]           out_cmd_q;
	logic [7:0]           out_arg_q;

	logic                 accept_rx, is_lf, wr_en, rd_en;
	logic                 scan_stop, match_last, out_free, load_out;
	logic [IW-1:0]        raw_len, eff_len;
	logic                 strip_cr;
	lcd_pkg::lcd_step_t   pctl;
	lcd_pkg::lcd_result_t pres;

	// Handshake and store access
	assign accept_rx = rx.valid && rx.ready;
	assign is_lf     = (rx.rx_byte == lcd_pkg::CH_LF);
	assign wr_en     = accept_rx && !is_lf && (fill_q < LAST);
	assign rd_en     = ((state_q == lcd_pkg::ST_SCAN) || (state_q == lcd_pkg::ST_MATCH)) &&
	                   (rd_q < len_q);

	lcd_ram #(
		.WIDTH (lcd_pkg::BYTE_W),
		.DEPTH (LINE_LENGTH)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (fill_q),
		.wdata (rx.rx_byte),
		.re    (rd_en),
		.raddr (rd_q),
		.rdata (rdata)
	);

	// Line end detection during the first sweep
	always_comb begin
		scan_stop = (state_q == lcd_pkg::ST_SCAN) && dv_s1 &&
		            ((rdata == lcd_pkg::CH_NUL) || (di_s1 == len_q - IW'(1)));
		if (rdata == lcd_pkg::CH_NUL) begin
			raw_len  = di_s1;
			strip_cr = (di_s1 != '0) && (last_q == lcd_pkg::CH_CR);
		end else begin
			raw_len  = len_q;
			strip_cr = (rdata == lcd_pkg::CH_CR);
		end
		eff_len = raw_len - IW'(strip_cr);
	end

	assign match_last = (state_q == lcd_pkg::ST_MATCH) && dv_s1 && (di_s1 == len_q - IW'(1));
	assign out_free   = !out_valid_q || cmd.ready;
	assign load_out   = (state_q == lcd_pkg::ST_FINISH) && pres.hit && out_free;

	// Parser control
	always_comb begin
		pctl.clear = scan_stop;
		pctl.step  = (state_q == lcd_pkg::ST_MATCH) && dv_s1;
		pctl.ch    = rdata;
	end

	lcd_parser #(
		.IW (IW)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (pctl),
		.idx    (di_s1),
		.len    (len_q),
		.res    (pres)
	);

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcd_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Sequencer next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			lcd_pkg::ST_IDLE: begin
				if (accept_rx && is_lf && (fill_q != '0)) begin
					state_nx = lcd_pkg::ST_SCAN;
				end
			end
			lcd_pkg::ST_SCAN: begin
				if (scan_stop) begin
					state_nx = (eff_len == '0) ? lcd_pkg::ST_IDLE : lcd_pkg::ST_MATCH;
				end
			end
			lcd_pkg::ST_MATCH: begin
				if (match_last) begin
					state_nx = lcd_pkg::ST_FINISH;
				end
			end
			lcd_pkg::ST_FINISH: begin
				if (!pres.hit || out_free) begin
					state_nx = lcd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = lcd_pkg::ST_IDLE;
			end
		endcase
	end

	assign rx.ready = (state_q == lcd_pkg::ST_IDLE);

	// Fill index, line length and read address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			len_q  <= '0;
			rd_q   <= '0;
			dv_s1  <= 1'b0;
		end else begin
			if (accept_rx) begin
				if (is_lf || (fill_q >= LAST)) begin
					fill_q <= '0;
				end else begin
					fill_q <= fill_q + IW'(1);
				end
			end
			if (accept_rx && is_lf) begin
				len_q <= fill_q;
			end else if (scan_stop) begin
				len_q <= eff_len;
			end
			if ((accept_rx && is_lf) || scan_stop) begin
				rd_q <= '0;
			end else if (rd_en) begin
				rd_q <= rd_q + IW'(1);
			end
			// drop a read in flight when the first sweep ends
			dv_s1 <= rd_en && !scan_stop;
		end
	end

	// Read tag and previous character
	always_ff @(posedge clk) begin
		if (rd_en) begin
			di_s1 <= rd_q;
		end
		if ((state_q == lcd_pkg::ST_SCAN) && dv_s1) begin
			last_q <= rdata;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (cmd.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_cmd_q <= pres.command;
			out_arg_q <= pres.argument;
		end
	end

	assign cmd.valid    = out_valid_q;
	assign cmd.command  = out_cmd_q;
	assign cmd.argument = out_arg_q;

`ifndef SYNTH
	a_result_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(cmd.valid) |-> $past(state_q == lcd_pkg::ST_FINISH))
		else $error("result raised outside finish state");

	a_no_write_while_decoding: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != lcd_pkg::ST_IDLE) |-> !wr_en)
		else $error("line store written during decode");

	a_match_index_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == lcd_pkg::ST_MATCH) && dv_s1) |-> (di_s1 < len_q))
		else $error("match sweep read beyond line end");
`endif

endmodule

FILE: rtl/lcd_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.

module lcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/lcd_parser.sv
// Character-serial command matcher with a shared multiply-by-ten accumulator.
// Depends on lcd_pkg for the command table and step/result structs.

module lcd_parser #(
	parameter int IW = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lcd_pkg::lcd_step_t   ctl,
	input  logic [IW-1:0]        idx,
	input  logic [IW-1:0]        len,
	output lcd_pkg::lcd_result_t res
);

	logic [lcd_pkg::NUM_CMDS-1:0] alive_q, alive_nx;
	logic [lcd_pkg::ARG_W-1:0]    acc_q, acc_nx;
	logic                         run_q;
	logic                         pmode_q;
	logic                         digit;
	logic [3:0]                   dval;
	logic [11:0]                  sum;
	logic [IW-1:0]                arg_start;

	// Digit decode and saturating accumulate
	always_comb begin
		digit     = (ctl.ch >= lcd_pkg::CH_ZERO) && (ctl.ch <= lcd_pkg::CH_NINE);
		dval      = 4'(ctl.ch - lcd_pkg::CH_ZERO);
		sum       = 12'(acc_q) * 12'd10 + 12'(dval);
		acc_nx    = (sum > 12'(lcd_pkg::ARG_MAX)) ? lcd_pkg::ARG_MAX : sum[7:0];
		arg_start = pmode_q ? IW'(8) : IW'(2);
	end

	// Per-command character compare at the current position
	always_comb begin
		lcd_pkg::cmd_code_t k_code;
		alive_nx = alive_q;
		for (int k = 0; k < lcd_pkg::NUM_CMDS; k++) begin
			k_code = lcd_pkg::cmd_code_t'(4'(k));
			if ((idx < IW'(lcd_pkg::cmd_len(k_code))) &&
			    (ctl.ch != lcd_pkg::cmd_char(k_code, idx[2:0]))) begin
				alive_nx[k] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= '1;
			acc_q   <= '0;
			run_q   <= 1'b1;
			pmode_q <= 1'b0;
		end else if (ctl.clear) begin
			alive_q <= '1;
			acc_q   <= '0;
			run_q   <= 1'b1;
			pmode_q <= 1'b0;
		end else if (ctl.step) begin
			alive_q <= alive_nx;
			if (idx == '0) begin
				pmode_q <= (ctl.ch == lcd_pkg::CH_P);
			end
			// argument digits start right after the prefix
			if ((idx >= arg_start) && run_q) begin
				if (digit) begin
					acc_q <= acc_nx;
				end else begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// Length check and priority pick, lowest code first
	always_comb begin
		lcd_pkg::cmd_code_t k_code;
		logic               len_ok;
		res.hit      = 1'b0;
		res.command  = lcd_pkg::CMD_FWD;
		res.argument = '0;
		for (int k = lcd_pkg::NUM_CMDS - 1; k >= 0; k--) begin
			k_code = lcd_pkg::cmd_code_t'(4'(k));
			len_ok = lcd_pkg::cmd_prefix(k_code) ?
			         (len >= IW'(lcd_pkg::cmd_len(k_code))) :
			         (len == IW'(lcd_pkg::cmd_len(k_code)));
			if (alive_q[k] && len_ok) begin
				res.hit      = 1'b1;
				res.command  = k_code;
				res.argument = lcd_pkg::cmd_prefix(k_code) ? acc_q : '0;
			end
		end
	end

endmodule
